// ===== src/rks_pkg.sv =====
`timescale 1ns / 1ps

package rks_pkg;

    // Store size and the widths that follow from it.
    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int KEY_W = 64;
    localparam int REC_W = 64;

    localparam logic [KEY_W-1:0] SIGN_BIT = {1'b1, {(KEY_W-1){1'b0}}};

    // One stored record.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [REC_W-1:0] rec;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Input transfer payload.
    typedef struct packed {
        logic [KEY_W-1:0] time_key;
        logic [REC_W-1:0] record_number;
        logic             last_in;
    } t_in;

    // Output transfer payload.
    typedef struct packed {
        logic [KEY_W-1:0] sorted_key;
        logic [REC_W-1:0] sorted_record;
        logic             last_out;
        logic             dropped;
    } t_out;

    // Maps a double bit pattern to an unsigned value with the same order.
    // Negative zero ranks with positive zero.
    function automatic logic [KEY_W-1:0] order_of(input logic [KEY_W-1:0] bits);
        logic [KEY_W-1:0] b;
        b = (bits == SIGN_BIT) ? '0 : bits;
        if (b[KEY_W-1]) begin
            return ~b;
        end
        return b | SIGN_BIT;
    endfunction

endpackage

// ===== src/rks_ram.sv =====
`timescale 1ns / 1ps

module rks_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port and one registered read port; read data holds when idle.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/record_key_sorter.sv =====
// Load: a record is accepted in S_LOAD, then in S_SHIFT each stored record with
// a larger key moves up a slot in turn before the new record is written. The
// store's single read port and single write port allow one move at a time.
// Emission: each result passes from the store via the read stage to the output
// register, one result per cycle while the receiver is ready. Reset clears the
// fill count and the drop flag; the record store is not cleared.
`timescale 1ns / 1ps

module record_key_sorter
    import rks_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    typedef enum logic [1:0] {
        S_LOAD,
        S_SHIFT,
        S_EMIT
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ovf, n_ovf;
    t_entry           r_new, n_new;
    logic [KEY_W-1:0] r_new_map, n_new_map;
    logic             r_new_last, n_new_last;
    logic [IDX_W-1:0] r_pos, n_pos;
    logic [CNT_W-1:0] r_emit_addr, n_emit_addr;
    logic             r_rd_valid, n_rd_valid;
    logic             r_rd_last, n_rd_last;
    t_out             r_out, n_out;
    logic             r_out_valid, n_out_valid;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_entry           wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    t_entry           rd_data;
    logic [ENTRY_W-1:0] rd_bits;

    logic             in_xfer;
    logic             out_xfer;
    logic             load_out;
    logic             issue;

    assign rd_data = t_entry'(rd_bits);

    rks_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_bits)
    );

    assign o_in_ready  = (r_state == S_LOAD);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_xfer = r_out_valid && i_out_ready;
    assign load_out = r_rd_valid && (!r_out_valid || i_out_ready);
    assign issue    = (r_state == S_EMIT) && (r_emit_addr < r_count)
                      && (!r_rd_valid || load_out);

    // Next-state logic: insertion by read, compare and shift, then streaming.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_new       = r_new;
        n_new_map   = r_new_map;
        n_new_last  = r_new_last;
        n_pos       = r_pos;
        n_emit_addr = r_emit_addr;
        n_rd_valid  = r_rd_valid;
        n_rd_last   = r_rd_last;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        wr_en       = 1'b0;
        wr_addr     = r_pos;
        wr_data     = r_new;
        rd_en       = 1'b0;
        rd_addr     = r_pos - IDX_W'(1);

        unique case (r_state)
            S_LOAD: begin
                if (in_xfer) begin
                    if (r_count < CNT_W'(CAPACITY)) begin
                        n_new.key  = i_in_data.time_key;
                        n_new.rec  = i_in_data.record_number;
                        n_new_map  = order_of(i_in_data.time_key);
                        n_new_last = i_in_data.last_in;
                        n_pos      = r_count[IDX_W-1:0];
                        n_count    = r_count + CNT_W'(1);
                        n_state    = S_SHIFT;
                        if (r_count != '0) begin
                            rd_en   = 1'b1;
                            rd_addr = r_count[IDX_W-1:0] - IDX_W'(1);
                        end
                    end else begin
                        // Store full: the record is discarded.
                        n_ovf = 1'b1;
                        if (i_in_data.last_in) begin
                            n_state     = S_EMIT;
                            n_emit_addr = '0;
                        end
                    end
                end
            end

            S_SHIFT: begin
                // The entry below the hole arrived from last cycle's read.
                if ((r_pos != '0) && (order_of(rd_data.key) > r_new_map)) begin
                    wr_en   = 1'b1;
                    wr_addr = r_pos;
                    wr_data = rd_data;
                    n_pos   = r_pos - IDX_W'(1);
                    if (r_pos != IDX_W'(1)) begin
                        rd_en   = 1'b1;
                        rd_addr = r_pos - IDX_W'(2);
                    end
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = r_pos;
                    wr_data = r_new;
                    if (r_new_last) begin
                        n_state     = S_EMIT;
                        n_emit_addr = '0;
                    end else begin
                        n_state = S_LOAD;
                    end
                end
            end

            S_EMIT: begin
                if (issue) begin
                    rd_en       = 1'b1;
                    rd_addr     = r_emit_addr[IDX_W-1:0];
                    n_emit_addr = r_emit_addr + CNT_W'(1);
                    n_rd_last   = (r_emit_addr == r_count - CNT_W'(1));
                    n_rd_valid  = 1'b1;
                end else if (load_out) begin
                    n_rd_valid = 1'b0;
                end

                if (load_out) begin
                    n_out.sorted_key    = rd_data.key;
                    n_out.sorted_record = rd_data.rec;
                    n_out.last_out      = r_rd_last;
                    n_out.dropped       = r_ovf;
                    n_out_valid         = 1'b1;
                end else if (out_xfer) begin
                    n_out_valid = 1'b0;
                end

                // The final transfer empties the block for the next set.
                if (out_xfer && r_out.last_out) begin
                    n_state = S_LOAD;
                    n_count = '0;
                    n_ovf   = 1'b0;
                end
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_rd_valid  <= n_rd_valid;
            r_out_valid <= n_out_valid;
        end
        r_new       <= n_new;
        r_new_map   <= n_new_map;
        r_new_last  <= n_new_last;
        r_pos       <= n_pos;
        r_emit_addr <= n_emit_addr;
        r_rd_last   <= n_rd_last;
        r_out       <= n_out;
    end

`ifndef NO_ASSERTIONS
    // No result is pending while records are being loaded.
    a_load_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("result pending while loading");

    // The fill count never passes the store size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("fill count beyond capacity");

    // The read stage only carries data while streaming.
    a_rd_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_valid |-> (r_state == S_EMIT))
        else $error("read stage busy outside emission");

    // After the final result of a set the block is ready to load again.
    a_last_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out_data.last_out) |=>
            (o_in_ready && (r_count == '0)))
        else $error("block not empty after final transfer");
`endif

endmodule
